// ===== hw/rtl/ctk_pkg.sv =====
// Shared types and constants for the interval timer and keyboard port block.
`default_nettype none
package ctk_pkg;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_JOY   = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // Register map
    localparam logic [3:0] ADDR_PRA  = 4'h0;
    localparam logic [3:0] ADDR_PRB  = 4'h1;
    localparam logic [3:0] ADDR_DDRA = 4'h2;
    localparam logic [3:0] ADDR_TALO = 4'h4;
    localparam logic [3:0] ADDR_TAHI = 4'h5;
    localparam logic [3:0] ADDR_TBLO = 4'h6;
    localparam logic [3:0] ADDR_TBHI = 4'h7;
    localparam logic [3:0] ADDR_ICR  = 4'hd;
    localparam logic [3:0] ADDR_CRA  = 4'he;
    localparam logic [3:0] ADDR_CRB  = 4'hf;

    // Control register bits
    localparam int CR_START   = 0;
    localparam int CR_ONESHOT = 3;
    localparam int CR_LOAD    = 4;
    localparam int ICR_SET    = 7;

    // One request as held in the input register
    typedef struct packed {
        t_action    action;
        logic [3:0] address;
        logic [7:0] data;
        logic [7:0] joy1;
        logic [7:0] joy2;
        logic [7:0] rows;
    } t_ctk_item;

    // Commands to one timer, decoded from a request
    typedef struct packed {
        logic       tick;
        logic       wr_lo;
        logic       wr_hi;
        logic       wr_ctrl;
        logic [7:0] data;
    } t_ctk_tmr_cmd;

endpackage
`default_nettype wire

// ===== hw/rtl/ctk_timer.sv =====
// One 16-bit interval timer with reload latch, force load and one-shot mode.
`default_nettype none
module ctk_timer
    import ctk_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire t_ctk_tmr_cmd i_cmd,
    output logic [15:0]       o_count_next,
    output logic              o_underflow
);

    logic [15:0] r_count, n_count;
    logic [15:0] r_reload, n_reload;
    logic        r_running, n_running;
    logic        r_oneshot, n_oneshot;

    always_comb begin
        n_count     = r_count;
        n_reload    = r_reload;
        n_running   = r_running;
        n_oneshot   = r_oneshot;
        o_underflow = 1'b0;
        if (i_cmd.tick && r_running) begin
            if (r_count[15:1] == 15'd0) begin
                // count of 0 or 1 underflows and reloads
                n_count     = r_reload;
                o_underflow = 1'b1;
                if (r_oneshot) begin
                    n_running = 1'b0;
                end
            end else begin
                n_count = r_count - 16'd1;
            end
        end
        if (i_cmd.wr_lo) begin
            n_reload = {r_reload[15:8], i_cmd.data};
        end
        if (i_cmd.wr_hi) begin
            n_reload = {i_cmd.data, r_reload[7:0]};
        end
        if (i_cmd.wr_ctrl) begin
            if (i_cmd.data[CR_LOAD]) begin
                n_count = r_reload;
            end
            n_running = i_cmd.data[CR_START];
            n_oneshot = i_cmd.data[CR_ONESHOT];
        end
    end

    assign o_count_next = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_reload  <= '0;
            r_running <= 1'b0;
            r_oneshot <= 1'b0;
        end else if (i_en) begin
            r_count   <= n_count;
            r_reload  <= n_reload;
            r_running <= n_running;
            r_oneshot <= n_oneshot;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ctk_port.sv =====
// Port A/B, keyboard column mask, joystick latches and interrupt mask.
`default_nettype none
module ctk_port
    import ctk_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_en,
    input  wire t_ctk_item i_item,
    output logic [7:0]     o_port_a_next,
    output logic [7:0]     o_port_b_next,
    output logic [7:0]     o_column_next,
    output logic [1:0]     o_imask
);

    logic [7:0] r_column, n_column;
    logic [7:0] r_joy1, n_joy1;
    logic [7:0] r_joy2, n_joy2;
    logic [7:0] r_pbv, n_pbv;
    logic [7:0] r_ddra, n_ddra;
    logic [7:0] r_imask, n_imask;

    always_comb begin
        n_column = r_column;
        n_joy1   = r_joy1;
        n_joy2   = r_joy2;
        n_pbv    = r_pbv;
        n_ddra   = r_ddra;
        n_imask  = r_imask;
        case (i_item.action)
            ACT_WRITE: begin
                case (i_item.address)
                    ADDR_PRA: begin
                        // input lines of port A read high
                        n_column = i_item.data | ~r_ddra;
                        n_pbv    = i_item.rows & r_joy1;
                    end
                    ADDR_PRB:  n_pbv  = i_item.data;
                    ADDR_DDRA: n_ddra = i_item.data;
                    ADDR_ICR: begin
                        if (i_item.data[ICR_SET]) begin
                            n_imask = r_imask | {1'b0, i_item.data[6:0]};
                        end else begin
                            n_imask = r_imask & ~i_item.data;
                        end
                    end
                    default: ;
                endcase
            end
            ACT_JOY: begin
                n_joy1 = i_item.joy1;
                n_joy2 = i_item.joy2;
                n_pbv  = i_item.rows & i_item.joy1;
            end
            default: ;
        endcase
    end

    assign o_port_a_next = n_column & n_joy2;
    assign o_port_b_next = n_pbv;
    assign o_column_next = n_column;
    assign o_imask       = r_imask[1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= '0;
            r_joy1   <= '0;
            r_joy2   <= '0;
            r_pbv    <= '0;
            r_ddra   <= '0;
            r_imask  <= '0;
        end else if (i_en) begin
            r_column <= n_column;
            r_joy1   <= n_joy1;
            r_joy2   <= n_joy2;
            r_pbv    <= n_pbv;
            r_ddra   <= n_ddra;
            r_imask  <= n_imask;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/cia_timer_and_keyboard_port.sv =====
// Top level: interval timers and keyboard/joystick port of the interface adapter.
`default_nettype none
// Each request is a register write, one clock tick, a joystick update or no
// action, and produces exactly one result: port A, port B, the column mask,
// an interrupt flag for this request and both timer counts after it. One
// request is taken every cycle as long as results are taken. A request is held
// in the input register, where the state update and result are computed, and
// then sits in the result register until taken. While a result is stalled,
// the input register still accepts one more request. Timers count down on
// ticks only; a count of 0 or 1 on a tick underflows and reloads from the
// latch, flagging irq when its mask bit (bit 0 for A, bit 1 for B) is set.
// A one-shot timer stops on underflow. Stopping a timer freezes its count
// exactly. Register reads, time of day and the serial port are not
// implemented.
module cia_timer_and_keyboard_port
    import ctk_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [3:0]  i_address,
    input  wire logic [7:0]  i_write_data,
    input  wire logic [7:0]  i_joy1,
    input  wire logic [7:0]  i_joy2,
    input  wire logic [7:0]  i_keyboard_rows,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_port_a,
    output logic [7:0]       o_port_b,
    output logic [7:0]       o_key_columns,
    output logic             o_irq,
    output logic [15:0]      o_timer_a_count,
    output logic [15:0]      o_timer_b_count
);

    logic         r_in_valid;
    t_ctk_item    r_item;
    logic         r_out_valid;
    logic         advance;
    logic         in_take;

    t_ctk_tmr_cmd cmd_a, cmd_b;
    logic [15:0]  cnt_a_next, cnt_b_next;
    logic         uf_a, uf_b;
    logic [7:0]   pa_next, pb_next, col_next;
    logic [1:0]   imask;
    logic         is_write;

    // The held request commits to the state when the result register is free.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item <= '{action:  t_action'(i_action),
                        address: i_address,
                        data:    i_write_data,
                        joy1:    i_joy1,
                        joy2:    i_joy2,
                        rows:    i_keyboard_rows};
        end
    end

    // Timer command decode
    assign is_write = (r_item.action == ACT_WRITE);
    always_comb begin
        cmd_a.tick    = (r_item.action == ACT_TICK);
        cmd_a.wr_lo   = is_write && (r_item.address == ADDR_TALO);
        cmd_a.wr_hi   = is_write && (r_item.address == ADDR_TAHI);
        cmd_a.wr_ctrl = is_write && (r_item.address == ADDR_CRA);
        cmd_a.data    = r_item.data;
        cmd_b.tick    = (r_item.action == ACT_TICK);
        cmd_b.wr_lo   = is_write && (r_item.address == ADDR_TBLO);
        cmd_b.wr_hi   = is_write && (r_item.address == ADDR_TBHI);
        cmd_b.wr_ctrl = is_write && (r_item.address == ADDR_CRB);
        cmd_b.data    = r_item.data;
    end

    ctk_timer u_timer_a (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (advance),
        .i_cmd        (cmd_a),
        .o_count_next (cnt_a_next),
        .o_underflow  (uf_a)
    );

    ctk_timer u_timer_b (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (advance),
        .i_cmd        (cmd_b),
        .o_count_next (cnt_b_next),
        .o_underflow  (uf_b)
    );

    ctk_port u_port (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (advance),
        .i_item        (r_item),
        .o_port_a_next (pa_next),
        .o_port_b_next (pb_next),
        .o_column_next (col_next),
        .o_imask       (imask)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            o_port_a        <= pa_next;
            o_port_b        <= pb_next;
            o_key_columns   <= col_next;
            o_irq           <= (uf_a && imask[0]) || (uf_b && imask[1]);
            o_timer_a_count <= cnt_a_next;
            o_timer_b_count <= cnt_b_next;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("result register empty after a request committed");
    a_stall_only_full: assert property (@(posedge i_clk)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with an empty input register");
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_in_valid && !r_out_valid)
        else $error("pipeline not empty after reset");
    a_irq_needs_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_item.action != ACT_TICK) |=> !o_irq)
        else $error("irq raised by a request that is not a tick");
`endif

endmodule
`default_nettype wire

// ===== dv/ctk_tb_pkg.sv =====
// Scoreboard with a cycle-free predictor of the timer and keyboard port block.
package ctk_tb_pkg;
    import ctk_pkg::*;

    typedef struct packed {
        logic [7:0]  port_a;
        logic [7:0]  port_b;
        logic [7:0]  key_columns;
        logic        irq;
        logic [15:0] timer_a;
        logic [15:0] timer_b;
    } t_port_result;

    class port_timer_scoreboard;
        logic [7:0]   regs [16];
        logic [7:0]   col_sel;
        logic [7:0]   joy_one;
        logic [7:0]   joy_two;
        logic [7:0]   port_b_val;
        logic [7:0]   int_enable;
        logic [15:0]  count_a;
        logic [15:0]  latch_a;
        logic [15:0]  count_b;
        logic [15:0]  latch_b;
        bit           run_a;
        bit           run_b;
        t_port_result port_results_due [$];
        int unsigned  results_seen;
        int unsigned  mismatches;

        function new();
            foreach (regs[i]) regs[i] = 8'h00;
            col_sel    = 8'h00;
            joy_one    = 8'h00;
            joy_two    = 8'h00;
            port_b_val = 8'h00;
            int_enable = 8'h00;
            count_a    = 16'h0000;
            latch_a    = 16'h0000;
            count_b    = 16'h0000;
            latch_b    = 16'h0000;
            run_a      = 1'b0;
            run_b      = 1'b0;
            results_seen = 0;
            mismatches   = 0;
        endfunction

        function int unsigned pending();
            return port_results_due.size();
        endfunction

        // One tick of one timer; true on underflow.
        function bit count_down(inout logic [15:0] count, input logic [15:0] latch,
                                inout bit running, input logic [3:0] ctrl);
            if (!running)
                return 1'b0;
            if (count <= 16'd1) begin
                count = latch;
                if (regs[ctrl][CR_ONESHOT]) begin
                    running = 1'b0;
                    regs[ctrl][CR_START] = 1'b0;
                end
                return 1'b1;
            end
            count = count - 16'd1;
            return 1'b0;
        endfunction

        function void write_reg(logic [3:0] addr, logic [7:0] wdata, logic [7:0] rows);
            logic [7:0] d;
            d = wdata;
            case (addr)
                ADDR_PRA: begin
                    d          = d | ~regs[ADDR_DDRA];
                    col_sel    = d;
                    port_b_val = rows & joy_one;
                    d          = d & joy_two;
                end
                ADDR_PRB:  port_b_val    = d;
                ADDR_TALO: latch_a[7:0]  = d;
                ADDR_TAHI: latch_a[15:8] = d;
                ADDR_TBLO: latch_b[7:0]  = d;
                ADDR_TBHI: latch_b[15:8] = d;
                ADDR_ICR: begin
                    if (d[ICR_SET])
                        int_enable = int_enable | {1'b0, d[6:0]};
                    else
                        int_enable = int_enable & ~d;
                    d = 8'h00;
                end
                ADDR_CRA: begin
                    if (d[CR_LOAD]) begin
                        count_a    = latch_a;
                        d[CR_LOAD] = 1'b0;
                    end
                    run_a = d[CR_START];
                end
                ADDR_CRB: begin
                    if (d[CR_LOAD]) begin
                        count_b    = latch_b;
                        d[CR_LOAD] = 1'b0;
                    end
                    run_b = d[CR_START];
                end
                default: ;
            endcase
            regs[addr] = d;
        endfunction

        // Accepted request: advance the state and queue the port values it yields.
        function void apply_request(t_ctk_item req);
            t_port_result want;
            bit           irq;
            irq = 1'b0;
            case (req.action)
                ACT_WRITE: write_reg(req.address, req.data, req.rows);
                ACT_TICK: begin
                    if (count_down(count_a, latch_a, run_a, ADDR_CRA) && int_enable[0])
                        irq = 1'b1;
                    if (count_down(count_b, latch_b, run_b, ADDR_CRB) && int_enable[1])
                        irq = 1'b1;
                end
                ACT_JOY: begin
                    joy_one        = req.joy1;
                    joy_two        = req.joy2;
                    port_b_val     = req.rows & req.joy1;
                    regs[ADDR_PRA] = col_sel & req.joy2;
                end
                default: ;
            endcase
            want.port_a      = col_sel & joy_two;
            want.port_b      = port_b_val;
            want.key_columns = col_sel;
            want.irq         = irq;
            want.timer_a     = count_a;
            want.timer_b     = count_b;
            port_results_due.push_back(want);
        endfunction

        task report_mismatch(input string msg);
            $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        task compare_result(input t_port_result got);
            t_port_result want;
            if (port_results_due.size() == 0) begin
                report_mismatch($sformatf("result %0h with nothing outstanding", got));
                return;
            end
            want = port_results_due.pop_front();
            if (got.port_a !== want.port_a)
                report_mismatch($sformatf("#%0d port_a %0h, want %0h",
                                          results_seen, got.port_a, want.port_a));
            if (got.port_b !== want.port_b)
                report_mismatch($sformatf("#%0d port_b %0h, want %0h",
                                          results_seen, got.port_b, want.port_b));
            if (got.key_columns !== want.key_columns)
                report_mismatch($sformatf("#%0d key_columns %0h, want %0h",
                                          results_seen, got.key_columns, want.key_columns));
            if (got.irq !== want.irq)
                report_mismatch($sformatf("#%0d irq %0b, want %0b",
                                          results_seen, got.irq, want.irq));
            if (got.timer_a !== want.timer_a)
                report_mismatch($sformatf("#%0d timer_a %0h, want %0h",
                                          results_seen, got.timer_a, want.timer_a));
            if (got.timer_b !== want.timer_b)
                report_mismatch($sformatf("#%0d timer_b %0h, want %0h",
                                          results_seen, got.timer_b, want.timer_b));
            results_seen++;
        endtask

        task check_leftover();
            if (port_results_due.size() != 0)
                report_mismatch($sformatf("%0d results never arrived",
                                          port_results_due.size()));
        endtask
    endclass

endpackage

// ===== dv/tb.sv =====
// Top-level testbench for the interval timer and keyboard/joystick port block.
module tb;
    import ctk_pkg::*;
    import ctk_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Run length guard: ends the run when the cycle count reaches the limit.
    localparam int unsigned CYCLE_LIMIT   = 200_000;
    localparam int unsigned RANDOM_ITEMS  = 750;
    localparam int unsigned DRAIN_AT      = 450;  // sender waits for an empty pipe here
    localparam int unsigned HOLD_AT       = 300;  // receiver blocks after this many results
    localparam int unsigned HOLD_CYCLES   = 64;
    localparam int unsigned SETTLE_CYCLES = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_action;
    logic [3:0]  i_address;
    logic [7:0]  i_write_data;
    logic [7:0]  i_joy1;
    logic [7:0]  i_joy2;
    logic [7:0]  i_keyboard_rows;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_port_a;
    logic [7:0]  o_port_b;
    logic [7:0]  o_key_columns;
    logic        o_irq;
    logic [15:0] o_timer_a_count;
    logic [15:0] o_timer_b_count;

    port_timer_scoreboard sb;
    int unsigned          cycle_count = 0;
    bit                   send_burst  = 1'b0;

    cia_timer_and_keyboard_port dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_address       (i_address),
        .i_write_data    (i_write_data),
        .i_joy1          (i_joy1),
        .i_joy2          (i_joy2),
        .i_keyboard_rows (i_keyboard_rows),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_port_a        (o_port_a),
        .o_port_b        (o_port_b),
        .o_key_columns   (o_key_columns),
        .o_irq           (o_irq),
        .o_timer_a_count (o_timer_a_count),
        .o_timer_b_count (o_timer_b_count)
    );

    // 4 ns clock, starting low so the first edge is a clean rising one
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Watchdog: a hung handshake ends the run as a failure
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Both channels are sampled at the rising edge; inputs only move at the
    // falling edge, so what is read here is what the block saw.
    always @(posedge i_clk) begin : port_monitor
        t_port_result seen;
        t_ctk_item    req;
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
                seen.port_a      = o_port_a;
                seen.port_b      = o_port_b;
                seen.key_columns = o_key_columns;
                seen.irq         = o_irq;
                seen.timer_a     = o_timer_a_count;
                seen.timer_b     = o_timer_b_count;
                sb.compare_result(seen);
            end
            if (i_in_valid && o_in_stall === 1'b0) begin
                req.action  = t_action'(i_action);
                req.address = i_address;
                req.data    = i_write_data;
                req.joy1    = i_joy1;
                req.joy2    = i_joy2;
                req.rows    = i_keyboard_rows;
                sb.apply_request(req);
            end
        end
    end

    // Result side: after each taken result, draw a random stall length, with
    // runs of no stalling, and one long block once enough results have
    // passed so the block fills up and pushes back on the request side.
    initial begin : result_sink
        int unsigned stall_left;
        int unsigned taken;
        bit          sink_burst;
        bit          held;
        stall_left  = 0;
        taken       = 0;
        sink_burst  = 1'b0;
        held        = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left != 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
                taken++;
                if ($urandom_range(0, 39) == 0)
                    sink_burst = !sink_burst;
                stall_left = sink_burst ? 0 : $urandom_range(0, 7);
                if (!held && taken == HOLD_AT) begin
                    held       = 1'b1;
                    stall_left = HOLD_CYCLES;
                end
            end
        end
    end

    function automatic t_ctk_item req_of(t_action act, logic [3:0] addr, logic [7:0] wdata,
                                         logic [7:0] j1, logic [7:0] j2, logic [7:0] rows);
        t_ctk_item r;
        r.action  = act;
        r.address = addr;
        r.data    = wdata;
        r.joy1    = j1;
        r.joy2    = j2;
        r.rows    = rows;
        return r;
    endfunction

    // Tick-heavy mix so timers actually reach underflow; writes lean on the
    // timer, interrupt and control registers, with small latch values most
    // of the time. Unused fields always carry random bits.
    function automatic t_ctk_item random_request();
        t_ctk_item   r;
        int unsigned pick;
        pick      = $urandom_range(0, 99);
        r.address = 4'($urandom_range(0, 15));
        r.data    = 8'($urandom_range(0, 255));
        r.joy1    = 8'($urandom_range(0, 255));
        r.joy2    = 8'($urandom_range(0, 255));
        r.rows    = 8'($urandom_range(0, 255));
        if (pick < 45)
            r.action = ACT_TICK;
        else if (pick < 80)
            r.action = ACT_WRITE;
        else if (pick < 93)
            r.action = ACT_JOY;
        else
            r.action = ACT_NONE;
        if (r.action == ACT_WRITE) begin
            case ($urandom_range(0, 3))
                0: ;  // any register
                1: r.address = 4'(ADDR_TALO + $urandom_range(0, 3));
                default: r.address = 4'(ADDR_ICR + $urandom_range(0, 2));
            endcase
            case (r.address)
                ADDR_TALO, ADDR_TBLO: begin
                    if ($urandom_range(0, 3) != 0)
                        r.data = 8'($urandom_range(0, 9));
                end
                ADDR_TAHI, ADDR_TBHI: begin
                    if ($urandom_range(0, 3) != 0)
                        r.data = 8'h00;
                end
                ADDR_CRA, ADDR_CRB: begin
                    if ($urandom_range(0, 3) != 0)
                        r.data[CR_START] = 1'b1;
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    // Offer one request: optional random gap, then hold it until taken.
    // Called right after an acceptance edge; each step assigns valid once.
    task automatic send_request(input t_ctk_item req);
        int unsigned gap;
        if ($urandom_range(0, 39) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 7);
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_action        <= req.action;
        i_address       <= req.address;
        i_write_data    <= req.data;
        i_joy1          <= req.joy1;
        i_joy2          <= req.joy2;
        i_keyboard_rows <= req.rows;
        do
            @(posedge i_clk);
        while (o_in_stall !== 1'b0);
    endtask

    // Stop offering and wait for every outstanding result to come back
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
    endtask

    initial begin : stimulus
        int unsigned n;
        sb              = new();
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_action        = ACT_NONE;
        i_address       = 4'h0;
        i_write_data    = 8'h00;
        i_joy1          = 8'h00;
        i_joy2          = 8'h00;
        i_keyboard_rows = 8'h00;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed ---
        // tick with both timers stopped, then the unused action with all ones
        send_request(req_of(ACT_TICK,  ADDR_PRA,  8'h00, 8'h00, 8'h00, 8'h00));
        send_request(req_of(ACT_NONE,  ADDR_CRB,  8'hff, 8'hff, 8'hff, 8'hff));
        // joystick lines, then port A with direction all input: mask is all ones
        send_request(req_of(ACT_JOY,   ADDR_PRA,  8'h00, 8'hff, 8'hff, 8'hff));
        send_request(req_of(ACT_WRITE, ADDR_PRA,  8'h00, 8'h00, 8'h00, 8'h5a));
        send_request(req_of(ACT_WRITE, ADDR_DDRA, 8'hff, 8'h00, 8'h00, 8'h00));
        send_request(req_of(ACT_WRITE, ADDR_PRA,  8'ha5, 8'h00, 8'h00, 8'hff));
        send_request(req_of(ACT_JOY,   ADDR_PRA,  8'h00, 8'h00, 8'h3c, 8'hff));
        send_request(req_of(ACT_WRITE, ADDR_PRB,  8'h96, 8'h00, 8'h00, 8'h00));
        // timer A continuous from 2, both interrupts enabled
        send_request(req_of(ACT_WRITE, ADDR_TALO, 8'h02, 8'h00, 8'h00, 8'h00));
        send_request(req_of(ACT_WRITE, ADDR_TAHI, 8'h00, 8'h00, 8'h00, 8'h00));
        send_request(req_of(ACT_WRITE, ADDR_ICR,  8'h83, 8'h00, 8'h00, 8'h00));
        send_request(req_of(ACT_WRITE, ADDR_CRA,  8'h11, 8'h00, 8'h00, 8'h00));
        send_request(req_of(ACT_TICK,  ADDR_PRA,  8'h00, 8'h00, 8'h00, 8'h00));
        send_request(req_of(ACT_TICK,  ADDR_PRA,  8'h00, 8'h00, 8'h00, 8'h00));
        // timer B with a zero latch underflows on every tick
        send_request(req_of(ACT_WRITE, ADDR_CRB,  8'h11, 8'h00, 8'h00, 8'h00));
        send_request(req_of(ACT_TICK,  ADDR_PRA,  8'h00, 8'h00, 8'h00, 8'h00));
        // one-shot on A: underflows once, then stays stopped
        send_request(req_of(ACT_WRITE, ADDR_CRA,  8'h19, 8'h00, 8'h00, 8'h00));
        send_request(req_of(ACT_TICK,  ADDR_PRA,  8'h00, 8'h00, 8'h00, 8'h00));
        send_request(req_of(ACT_TICK,  ADDR_PRA,  8'h00, 8'h00, 8'h00, 8'h00));
        // clear both mask bits: B keeps underflowing without irq
        send_request(req_of(ACT_WRITE, ADDR_ICR,  8'h03, 8'h00, 8'h00, 8'h00));
        send_request(req_of(ACT_TICK,  ADDR_PRA,  8'h00, 8'h00, 8'h00, 8'h00));
        send_request(req_of(ACT_WRITE, ADDR_CRB,  8'h00, 8'h00, 8'h00, 8'h00));
        // full-scale latch, one tick, then stop: count must freeze exactly
        send_request(req_of(ACT_WRITE, ADDR_TALO, 8'hff, 8'h00, 8'h00, 8'h00));
        send_request(req_of(ACT_WRITE, ADDR_TAHI, 8'hff, 8'h00, 8'h00, 8'h00));
        send_request(req_of(ACT_WRITE, ADDR_CRA,  8'h11, 8'h00, 8'h00, 8'h00));
        send_request(req_of(ACT_TICK,  ADDR_PRA,  8'h00, 8'h00, 8'h00, 8'h00));
        send_request(req_of(ACT_WRITE, ADDR_CRA,  8'h00, 8'h00, 8'h00, 8'h00));

        // --- random ---
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == DRAIN_AT)
                drain_results();
            send_request(random_request());
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        sb.check_leftover();
        if (sb.mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
